>>> rtl/mbsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbsp_pkg: shared types and constants for the 1-bpp bitmap stream decoder
// Transaction payloads, result kinds, parser phases and header byte positions.
// ----------------------------------------------------------------------------
package mbsp_pkg;

    localparam int SCREEN_W_DEF = 128;
    localparam int SCREEN_H_DEF = 64;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [15:0] SIGNATURE  = 16'h4D42;
    localparam logic [31:0] MIN_OFFSET = 32'd30;

    localparam logic [31:0] POS_SIG_B0   = 32'd0;
    localparam logic [31:0] POS_SIG_B1   = 32'd1;
    localparam logic [31:0] POS_OFF_B0   = 32'd10;
    localparam logic [31:0] POS_OFF_B1   = 32'd11;
    localparam logic [31:0] POS_OFF_B2   = 32'd12;
    localparam logic [31:0] POS_OFF_B3   = 32'd13;
    localparam logic [31:0] POS_WID_B0   = 32'd18;
    localparam logic [31:0] POS_WID_B1   = 32'd19;
    localparam logic [31:0] POS_WID_B2   = 32'd20;
    localparam logic [31:0] POS_WID_B3   = 32'd21;
    localparam logic [31:0] POS_HGT_B0   = 32'd22;
    localparam logic [31:0] POS_HGT_B1   = 32'd23;
    localparam logic [31:0] POS_HGT_B2   = 32'd24;
    localparam logic [31:0] POS_HGT_B3   = 32'd25;
    localparam logic [31:0] POS_DEPTH_B0 = 32'd28;
    localparam logic [31:0] POS_DEPTH_B1 = 32'd29;

    typedef enum logic [2:0] {
        KIND_PIXEL      = 3'd0,
        KIND_DONE       = 3'd1,
        KIND_BAD_SIG    = 3'd2,
        KIND_BAD_SIZE   = 3'd3,
        KIND_BAD_DEPTH  = 3'd4,
        KIND_BAD_OFFSET = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_SKIP     = 2'd1,
        PH_PIXELS   = 2'd2,
        PH_FINISHED = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic       last;
    } out_t;

    typedef struct packed {
        logic       is_err;
        kind_t      err_kind;
        logic [7:0] mask;
        logic [6:0] x_base;
        logic [5:0] y;
        logic       done;
    } job_t;

endpackage
`default_nettype wire

>>> rtl/mono_bmp_stream_to_pixels_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_bmp_stream_to_pixels_top: streaming 1-bpp bitmap decoder
// Input channel in_valid/in_ready/in_data carries one file byte per
// transaction, start_of_file set on byte 0. Output channel
// out_valid/out_ready/out_data carries pixel writes (kind pixel, centred
// screen position), a done marker after the last pixel byte, or one error
// code; last marks the final result caused by a byte.
// A four-entry job queue sits between parser and emitter; bytes causing no
// result never enter it. The parser takes one byte per cycle while the
// queue is not full; the emitter writes one result per cycle into the output
// register while the receiver takes them, so a pixel byte with n clear bits
// in the image gives n pixel writes (n + 1 with done).
// Reset: parser back to header phase at position 0, queue and output empty.
// When the receiver stalls the output register holds, the emitter waits,
// the queue fills and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module mono_bmp_stream_to_pixels_top #(
    parameter int SCREEN_W = mbsp_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mbsp_pkg::SCREEN_H_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mbsp_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mbsp_pkg::out_t      out_data
);

    logic            push, pop, empty, full;
    mbsp_pkg::job_t  push_job, head;

    mbsp_front #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    mbsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    mbsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

>>> rtl/mbsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbsp_front: header parser and byte classifier
// Tracks the file position, captures and checks the header, walks the pixel
// rows and turns each byte causing a result into a job for the pixel emitter.
// ----------------------------------------------------------------------------
module mbsp_front #(
    parameter int SCREEN_W = mbsp_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mbsp_pkg::SCREEN_H_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mbsp_pkg::in_t  in_data,
    output logic                push,
    output mbsp_pkg::job_t      push_job,
    input  wire logic           full
);

    localparam int COL_W   = $clog2(SCREEN_W);
    localparam int ROW_W   = $clog2(SCREEN_H);
    localparam int MAX_PAD = ((SCREEN_W + 31) / 32) * 4;
    localparam int BIR_W   = $clog2(MAX_PAD);
    localparam logic [31:0] LIM_W = 32'(SCREEN_W);
    localparam logic [31:0] LIM_H = 32'(SCREEN_H);

    function automatic logic dim_bad(input logic [31:0] v, input logic [31:0] lim);
        dim_bad = (v == 32'd0) || v[31] || (v > lim);
    endfunction

    logic                   accept;
    mbsp_pkg::phase_t       phase_reg, phase_next, cur_phase;
    logic [31:0]            pos_reg, pos_next, cur_pos;
    logic [31:0]            offset_reg, offset_next;
    logic [31:0]            width_reg, width_next;
    logic [31:0]            height_reg, height_next;
    logic [7:0]             sig_lo_reg, sig_lo_next;
    logic [7:0]             depth_lo_reg, depth_lo_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [ROW_W-1:0]       oy_reg, oy_next;
    logic [COL_W-1:0]       ox_reg, ox_next;
    logic [BIR_W-1:0]       bir_reg, bir_next;

    logic [7:0]             b;
    logic                   at_sig, sig_bad, at_check, size_bad, depth_bad, offset_bad;
    logic                   check_bad, in_pix, in_used, row_end, last_row;
    logic [8:0]             w9;
    logic [9:0]             used_sum, pad_sum;
    logic [5:0]             used;
    logic [BIR_W:0]         padded, bir_inc;
    logic [8:0]             col_base;
    logic [7:0]             pix_mask;
    logic [9:0]             x_sum;
    logic [8:0]             y_sum;

    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;
    assign b         = in_data.data_byte;
    assign cur_phase = in_data.start_of_file ? mbsp_pkg::PH_HEADER : phase_reg;
    assign cur_pos   = in_data.start_of_file ? 32'd0 : pos_reg;
    assign pos_next  = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;

    always_comb
    begin
        at_sig     = (cur_phase == mbsp_pkg::PH_HEADER) && (cur_pos == mbsp_pkg::POS_SIG_B1);
        sig_bad    = {b, sig_lo_reg} != mbsp_pkg::SIGNATURE;
        at_check   = (cur_phase == mbsp_pkg::PH_HEADER) && (cur_pos == mbsp_pkg::POS_DEPTH_B1);
        size_bad   = dim_bad(width_reg, LIM_W) || dim_bad(height_reg, LIM_H);
        depth_bad  = {b, depth_lo_reg} != 16'd1;
        offset_bad = offset_reg < mbsp_pkg::MIN_OFFSET;
        check_bad  = size_bad || depth_bad || offset_bad;
        in_pix     = (cur_phase == mbsp_pkg::PH_PIXELS)
                  || ((cur_phase == mbsp_pkg::PH_SKIP) && (cur_pos >= offset_reg));

        w9       = width_reg[8:0];
        used_sum = {1'b0, w9} + 10'd7;
        used     = used_sum[8:3];
        pad_sum  = {1'b0, w9} + 10'd31;
        padded   = (BIR_W + 1)'({pad_sum[9:5], 2'b00});
        bir_inc  = {1'b0, bir_reg} + (BIR_W + 1)'(1);
        row_end  = bir_inc >= padded;
        last_row = row_reg == '0;
        in_used  = 6'(bir_reg) < used;
        col_base = 9'({bir_reg, 3'b000});
        for (int k = 0; k < 8; k++)
        begin
            pix_mask[k] = ((col_base + 9'(k)) < w9) && !b[3'(7 - k)];
        end
        x_sum = 10'(ox_reg) + 10'(col_base);
        y_sum = 9'(oy_reg) + 9'(row_reg);
    end

    // next phase
    always_comb
    begin
        phase_next = cur_phase;
        unique case (cur_phase) inside
            mbsp_pkg::PH_HEADER:
            begin
                if (at_sig && sig_bad)
                    phase_next = mbsp_pkg::PH_FINISHED;
                else if (at_check)
                    phase_next = check_bad ? mbsp_pkg::PH_FINISHED : mbsp_pkg::PH_SKIP;
            end
            mbsp_pkg::PH_SKIP, mbsp_pkg::PH_PIXELS:
            begin
                if (in_pix)
                    phase_next = (row_end && last_row) ? mbsp_pkg::PH_FINISHED
                                                       : mbsp_pkg::PH_PIXELS;
            end
            mbsp_pkg::PH_FINISHED:
            begin
                phase_next = mbsp_pkg::PH_FINISHED;
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    // header capture and row walk
    always_comb
    begin
        offset_next   = offset_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        sig_lo_next   = sig_lo_reg;
        depth_lo_next = depth_lo_reg;
        row_next      = row_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        bir_next      = bir_reg;
        if (cur_phase == mbsp_pkg::PH_HEADER)
        begin
            case (cur_pos)
                mbsp_pkg::POS_SIG_B0:   sig_lo_next         = b;
                mbsp_pkg::POS_OFF_B0:   offset_next[7:0]    = b;
                mbsp_pkg::POS_OFF_B1:   offset_next[15:8]   = b;
                mbsp_pkg::POS_OFF_B2:   offset_next[23:16]  = b;
                mbsp_pkg::POS_OFF_B3:   offset_next[31:24]  = b;
                mbsp_pkg::POS_WID_B0:   width_next[7:0]     = b;
                mbsp_pkg::POS_WID_B1:   width_next[15:8]    = b;
                mbsp_pkg::POS_WID_B2:   width_next[23:16]   = b;
                mbsp_pkg::POS_WID_B3:   width_next[31:24]   = b;
                mbsp_pkg::POS_HGT_B0:   height_next[7:0]    = b;
                mbsp_pkg::POS_HGT_B1:   height_next[15:8]   = b;
                mbsp_pkg::POS_HGT_B2:   height_next[23:16]  = b;
                mbsp_pkg::POS_HGT_B3:   height_next[31:24]  = b;
                mbsp_pkg::POS_DEPTH_B0: depth_lo_next       = b;
                default:                ;
            endcase
        end
        if (at_check && !check_bad)
        begin
            ox_next  = COL_W'((LIM_W - width_reg) >> 1);
            oy_next  = ROW_W'((LIM_H - height_reg) >> 1);
            row_next = ROW_W'(height_reg - 32'd1);
            bir_next = '0;
        end
        else if (in_pix)
        begin
            if (row_end)
            begin
                bir_next = '0;
                if (!last_row)
                    row_next = row_reg - ROW_W'(1);
            end
            else
            begin
                bir_next = bir_inc[BIR_W-1:0];
            end
        end
    end

    // job for the emitter
    always_comb
    begin
        push_job          = '0;
        push_job.err_kind = mbsp_pkg::KIND_PIXEL;
        push              = 1'b0;
        if (at_sig && sig_bad)
        begin
            push_job.is_err   = 1'b1;
            push_job.err_kind = mbsp_pkg::KIND_BAD_SIG;
            push              = accept;
        end
        else if (at_check && check_bad)
        begin
            push_job.is_err = 1'b1;
            if (size_bad)
                push_job.err_kind = mbsp_pkg::KIND_BAD_SIZE;
            else if (depth_bad)
                push_job.err_kind = mbsp_pkg::KIND_BAD_DEPTH;
            else
                push_job.err_kind = mbsp_pkg::KIND_BAD_OFFSET;
            push = accept;
        end
        else if (in_pix)
        begin
            push_job.mask   = in_used ? pix_mask : 8'h00;
            push_job.x_base = x_sum[6:0];
            push_job.y      = y_sum[5:0];
            push_job.done   = row_end && last_row;
            push            = accept && ((|push_job.mask) || push_job.done);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mbsp_pkg::PH_HEADER;
            pos_reg      <= '0;
            offset_reg   <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            sig_lo_reg   <= '0;
            depth_lo_reg <= '0;
            row_reg      <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            bir_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            offset_reg   <= offset_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            sig_lo_reg   <= sig_lo_next;
            depth_lo_reg <= depth_lo_next;
            row_reg      <= row_next;
            ox_reg       <= ox_next;
            oy_reg       <= oy_next;
            bir_reg      <= bir_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/mbsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbsp_queue: job queue between parser and emitter
// Small register FIFO so that parser and emitter stall independently.
// ----------------------------------------------------------------------------
module mbsp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mbsp_pkg::job_t  push_job,
    input  wire logic            pop,
    output mbsp_pkg::job_t       head,
    output logic                 empty,
    output logic                 full
);

    localparam int DEPTH = mbsp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    mbsp_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign head  = mem[rd_ptr_reg];
    assign empty = count_reg == '0;
    assign full  = count_reg == (PTR_W + 1)'(DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + (PTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W + 1)'(DEPTH))
        else $error("job queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from empty queue");

endmodule
`default_nettype wire

>>> rtl/mbsp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbsp_back: pixel emitter
// Expands the head job of the queue, one result per cycle while the receiver
// takes them, into the output register: pixels, then done, or one error code.
// ----------------------------------------------------------------------------
module mbsp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mbsp_pkg::job_t  head,
    input  wire logic            empty,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mbsp_pkg::out_t       out_data
);

    logic            out_valid_reg, out_valid_next;
    mbsp_pkg::out_t  out_data_reg, out_data_next;
    logic [7:0]      used_reg, used_next;
    logic [7:0]      rem, rem_after, bit_sel;
    logic [2:0]      k;
    logic            gen, final_res;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        rem = head.mask & ~used_reg;
        k   = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (rem[i])
                k = 3'(i);
        end
        bit_sel   = 8'(1) << k;
        rem_after = rem & ~bit_sel;
        gen       = !empty && (!out_valid_reg || out_ready);

        out_data_next = '0;
        final_res     = 1'b1;
        if (head.is_err)
        begin
            out_data_next.kind = head.err_kind;
            out_data_next.last = 1'b1;
        end
        else if (rem != 8'h00)
        begin
            out_data_next.kind    = mbsp_pkg::KIND_PIXEL;
            out_data_next.pixel_x = head.x_base + 7'(k);
            out_data_next.pixel_y = head.y;
            final_res             = (rem_after == 8'h00) && !head.done;
            out_data_next.last    = final_res;
        end
        else
        begin
            out_data_next.kind = mbsp_pkg::KIND_DONE;
            out_data_next.last = 1'b1;
        end

        pop       = gen && final_res;
        used_next = used_reg;
        if (pop)
            used_next = 8'h00;
        else if (gen && !head.is_err && (rem != 8'h00))
            used_next = used_reg | bit_sel;

        if (gen)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (gen)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            used_reg      <= 8'h00;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
        end
    end

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && out_data_reg.last)
        else $error("job retired without a final result");

    a_only_pixel_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.last) |-> (out_data_reg.kind == mbsp_pkg::KIND_PIXEL))
        else $error("non-pixel result not marked last");

    a_pixels_left: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !head.is_err && !head.done) |-> (rem != 8'h00))
        else $error("pixel job at head with no pixels left");

endmodule
`default_nettype wire

>>> test/mono_bmp_stream_to_pixels_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bmp_stream_to_pixels_top_tb: self-checking bench for the 1-bpp decoder
// Streams whole bitmap files byte by byte: a crafted set first (missing start
// flag, every header fault, a full-width image, truncation, including of a
// full-height file, restart mid-file), then random mostly well-formed files.
// Each accepted byte runs through a behavioural decoder that queues the pixel
// writes, done and fault results it should cause; every result transaction is
// checked in order against that queue. Both sides idle in random bursts, the
// receiver holds off once for long, and the sender drains before some files.
// ----------------------------------------------------------------------------
module mono_bmp_stream_to_pixels_top_tb;

    localparam logic [31:0] SCR_W         = 32'(mbsp_pkg::SCREEN_W_DEF);
    localparam logic [31:0] SCR_H         = 32'(mbsp_pkg::SCREEN_H_DEF);
    localparam int          ITEMS         = 480;
    localparam int          CALM_TAIL     = 120;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          TAIL_CYCLES   = 32;
    localparam int          CYCLE_LIMIT   = 800_000;
    localparam int          PRINT_LIMIT   = 40;

    typedef struct {
        mbsp_pkg::in_t payload;
        bit            drain_first;
        bit            sink_stall;
    } feed_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    mbsp_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    mbsp_pkg::out_t out_data;

    feed_t          byte_feed[$];
    mbsp_pkg::out_t expected_px[$];

    int   mismatches    = 0;
    int   cycle_count   = 0;
    int   stream_bytes  = 0;
    int   files_queued  = 0;
    int   bytes_taken   = 0;
    int   pixels_seen   = 0;
    int   done_seen     = 0;
    int   faults_seen   = 0;
    int   src_gap       = 0;
    int   sink_gap      = 0;
    int   sink_hold     = 0;
    int   src_rate      = 4;
    int   sink_rate     = 4;
    logic sink_kick     = 1'b0;

    // decoder state
    logic [31:0]       dec_pos;
    logic [31:0]       dec_offset;
    logic [31:0]       dec_width;
    logic [31:0]       dec_height;
    logic [15:0]       dec_depth;
    logic [15:0]       dec_sig;
    mbsp_pkg::phase_t  dec_phase;
    logic [6:0]        dec_row;
    logic [4:0]        dec_col_byte;
    logic [6:0]        dec_org_x;
    logic [5:0]        dec_org_y;

    mono_bmp_stream_to_pixels_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit size_bad(input logic [31:0] v, input logic [31:0] limit);
        return v == 32'd0 || v[31] || v > limit;
    endfunction

    function automatic mbsp_pkg::out_t result_of(input mbsp_pkg::kind_t k, input int x,
                                                 input int y);
        mbsp_pkg::out_t r;
        r.kind    = k;
        r.pixel_x = 7'(x);
        r.pixel_y = 6'(y);
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic decoder_clear();
        dec_pos      = '0;
        dec_offset   = '0;
        dec_width    = '0;
        dec_height   = '0;
        dec_depth    = '0;
        dec_sig      = '0;
        dec_phase    = mbsp_pkg::PH_HEADER;
        dec_row      = '0;
        dec_col_byte = '0;
        dec_org_x    = '0;
        dec_org_y    = '0;
    endtask

    task automatic decode_byte(input mbsp_pkg::in_t item);
        logic [7:0]     b;
        logic [31:0]    at;
        int             used;
        int             padded;
        int             col;
        mbsp_pkg::out_t r;
        mbsp_pkg::out_t batch[$];
        b = item.data_byte;
        if (item.start_of_file)
            decoder_clear();
        at = dec_pos;
        if (dec_pos != 32'hFFFF_FFFF)
            dec_pos = dec_pos + 32'd1;
        case (dec_phase)
            mbsp_pkg::PH_HEADER:
            begin
                if (at <= mbsp_pkg::POS_SIG_B1)
                begin
                    dec_sig = dec_sig | 16'(32'(b) << (8 * at));
                    if (at == mbsp_pkg::POS_SIG_B1 && dec_sig != mbsp_pkg::SIGNATURE)
                    begin
                        batch     = {batch, result_of(mbsp_pkg::KIND_BAD_SIG, 0, 0)};
                        dec_phase = mbsp_pkg::PH_FINISHED;
                    end
                end
                else if (at >= mbsp_pkg::POS_OFF_B0 && at <= mbsp_pkg::POS_OFF_B3)
                    dec_offset = dec_offset | (32'(b) << (8 * (at - mbsp_pkg::POS_OFF_B0)));
                else if (at >= mbsp_pkg::POS_WID_B0 && at <= mbsp_pkg::POS_WID_B3)
                    dec_width = dec_width | (32'(b) << (8 * (at - mbsp_pkg::POS_WID_B0)));
                else if (at >= mbsp_pkg::POS_HGT_B0 && at <= mbsp_pkg::POS_HGT_B3)
                    dec_height = dec_height | (32'(b) << (8 * (at - mbsp_pkg::POS_HGT_B0)));
                else if (at == mbsp_pkg::POS_DEPTH_B0 || at == mbsp_pkg::POS_DEPTH_B1)
                begin
                    dec_depth = dec_depth
                              | 16'(32'(b) << (8 * (at - mbsp_pkg::POS_DEPTH_B0)));
                    if (at == mbsp_pkg::POS_DEPTH_B1)
                    begin
                        if (size_bad(dec_width, SCR_W) || size_bad(dec_height, SCR_H))
                        begin
                            batch     = {batch, result_of(mbsp_pkg::KIND_BAD_SIZE, 0, 0)};
                            dec_phase = mbsp_pkg::PH_FINISHED;
                        end
                        else if (dec_depth != 16'd1)
                        begin
                            batch     = {batch, result_of(mbsp_pkg::KIND_BAD_DEPTH, 0, 0)};
                            dec_phase = mbsp_pkg::PH_FINISHED;
                        end
                        else if (dec_offset < mbsp_pkg::MIN_OFFSET)
                        begin
                            batch     = {batch, result_of(mbsp_pkg::KIND_BAD_OFFSET, 0, 0)};
                            dec_phase = mbsp_pkg::PH_FINISHED;
                        end
                        else
                        begin
                            dec_org_x    = 7'((SCR_W - dec_width) >> 1);
                            dec_org_y    = 6'((SCR_H - dec_height) >> 1);
                            dec_row      = 7'(dec_height - 32'd1);
                            dec_col_byte = '0;
                            dec_phase    = mbsp_pkg::PH_SKIP;
                        end
                    end
                end
            end
            mbsp_pkg::PH_SKIP, mbsp_pkg::PH_PIXELS:
            begin
                if (dec_phase == mbsp_pkg::PH_SKIP && at >= dec_offset)
                    dec_phase = mbsp_pkg::PH_PIXELS;
                if (dec_phase == mbsp_pkg::PH_PIXELS)
                begin
                    used   = (int'(dec_width) + 7) / 8;
                    padded = ((int'(dec_width) + 31) / 32) * 4;
                    if (int'(dec_col_byte) < used)
                    begin
                        for (int k = 0; k < 8; k++)
                        begin
                            col = int'(dec_col_byte) * 8 + k;
                            if (col < int'(dec_width) && !b[7 - k])
                                batch = {batch, result_of(mbsp_pkg::KIND_PIXEL,
                                                          int'(dec_org_x) + col,
                                                          int'(dec_org_y) + int'(dec_row))};
                        end
                    end
                    dec_col_byte = dec_col_byte + 5'd1;
                    if (int'(dec_col_byte) >= padded)
                    begin
                        dec_col_byte = '0;
                        if (dec_row == '0)
                        begin
                            batch     = {batch, result_of(mbsp_pkg::KIND_DONE, 0, 0)};
                            dec_phase = mbsp_pkg::PH_FINISHED;
                        end
                        else
                            dec_row = dec_row - 7'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < batch.size(); i++)
        begin
            r           = batch[i];
            r.last      = (i == batch.size() - 1);
            expected_px = {expected_px, r};
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] result %0d: %s", $realtime, pixels_seen + done_seen + faults_seen,
                     what);
        mismatches++;
    endtask

    task automatic queue_file(input logic [15:0] sig, input logic [31:0] offset,
                              input logic [31:0] width, input logic [31:0] height,
                              input logic [15:0] depth, input bit flagged, input int cut,
                              input int trail, input bit drain, input bit stall);
        bit         good;
        int         len;
        int         padded;
        logic [7:0] b;
        feed_t      f;
        good = sig == mbsp_pkg::SIGNATURE && !size_bad(width, SCR_W)
               && !size_bad(height, SCR_H) && depth == 16'd1
               && offset >= mbsp_pkg::MIN_OFFSET && offset < 32'd4096;
        padded = ((int'(width & 32'hFF) + 31) / 32) * 4;
        len = good ? int'(offset) + int'(height) * padded : 30;
        if (cut >= 0 && cut < len)
            len = cut;
        for (int i = 0; i < len + trail; i++)
        begin
            b = 8'($urandom);
            if (i >= len)
                ;
            else if (i == mbsp_pkg::POS_SIG_B0)
                b = sig[7:0];
            else if (i == mbsp_pkg::POS_SIG_B1)
                b = sig[15:8];
            else if (i >= mbsp_pkg::POS_OFF_B0 && i <= mbsp_pkg::POS_OFF_B3)
                b = offset[8 * (i - mbsp_pkg::POS_OFF_B0) +: 8];
            else if (i >= mbsp_pkg::POS_WID_B0 && i <= mbsp_pkg::POS_WID_B3)
                b = width[8 * (i - mbsp_pkg::POS_WID_B0) +: 8];
            else if (i >= mbsp_pkg::POS_HGT_B0 && i <= mbsp_pkg::POS_HGT_B3)
                b = height[8 * (i - mbsp_pkg::POS_HGT_B0) +: 8];
            else if (i == mbsp_pkg::POS_DEPTH_B0)
                b = depth[7:0];
            else if (i == mbsp_pkg::POS_DEPTH_B1)
                b = depth[15:8];
            else if (good && i >= int'(offset))
            begin
                case ($urandom_range(0, 3))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    2:       b = 8'($urandom & $urandom);
                    default: b = 8'($urandom);
                endcase
            end
            f.payload.data_byte     = b;
            f.payload.start_of_file = (i == 0) ? flagged : (i >= len && $urandom_range(0, 15) == 0);
            f.drain_first           = (i == 0) && drain;
            f.sink_stall            = stall && good && i == int'(offset);
            byte_feed               = {byte_feed, f};
        end
        stream_bytes += len;
        files_queued++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_px.size());
            $display("mono_bmp_stream_to_pixels_top: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count % 512 == 0)
        begin
            src_rate  <= $urandom_range(0, 3) * 5;
            sink_rate <= $urandom_range(0, 3) * 5;
        end
    end

    always @(posedge clk)
    begin : feeder
        feed_t         head;
        logic          nxt_valid;
        mbsp_pkg::in_t nxt_data;
        logic          nxt_kick;
        int            nxt_gap;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            sink_kick <= 1'b0;
            src_gap   <= 0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_data  = in_data;
            nxt_kick  = 1'b0;
            nxt_gap   = src_gap;
            if (!in_valid || in_ready)
            begin
                nxt_valid = 1'b0;
                if (src_gap != 0)
                    nxt_gap = src_gap - 1;
                else if (byte_feed.size() != 0)
                begin
                    if (byte_feed[0].drain_first && (in_valid || expected_px.size() != 0))
                        ;
                    else if (byte_feed.size() >= CALM_TAIL && src_rate != 0
                             && $urandom_range(1, src_rate) == 1)
                        nxt_gap = $urandom_range(0, 16);
                    else
                    begin
                        head      = byte_feed.pop_front();
                        nxt_valid = 1'b1;
                        nxt_data  = head.payload;
                        nxt_kick  = head.sink_stall;
                    end
                end
            end
            in_valid  <= nxt_valid;
            in_data   <= nxt_data;
            sink_kick <= nxt_kick;
            src_gap   <= nxt_gap;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            sink_hold <= 0;
        else if (sink_kick)
            sink_hold <= HOLD_CYCLES;
        else if (sink_hold != 0)
            sink_hold <= sink_hold - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap  <= 0;
        end
        else if (sink_hold != 0)
            out_ready <= 1'b0;
        else if (sink_gap != 0)
        begin
            out_ready <= 1'b0;
            sink_gap  <= sink_gap - 1;
        end
        else if (byte_feed.size() >= CALM_TAIL && sink_rate != 0
                 && $urandom_range(1, sink_rate) == 1)
        begin
            out_ready <= 1'b0;
            sink_gap  <= $urandom_range(0, 16);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        mbsp_pkg::out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_px.size() == 0)
                    report_mismatch($sformatf("unexpected kind %0d x %0d y %0d last %0b",
                                              out_data.kind, out_data.pixel_x,
                                              out_data.pixel_y, out_data.last));
                else
                begin
                    want = expected_px.pop_front();
                    if (out_data.kind !== want.kind || out_data.pixel_x !== want.pixel_x
                        || out_data.pixel_y !== want.pixel_y || out_data.last !== want.last)
                        report_mismatch($sformatf(
                            "got kind %0d x %0d y %0d last %0b, want kind %0d x %0d y %0d last %0b",
                            out_data.kind, out_data.pixel_x, out_data.pixel_y, out_data.last,
                            want.kind, want.pixel_x, want.pixel_y, want.last));
                end
                case (out_data.kind)
                    mbsp_pkg::KIND_PIXEL: pixels_seen++;
                    mbsp_pkg::KIND_DONE:  done_seen++;
                    default:              faults_seen++;
                endcase
            end
            if (in_valid && in_ready)
            begin
                decode_byte(in_data);
                bytes_taken++;
            end
        end
    end

    initial
    begin : stimulus
        logic [15:0] sig;
        logic [15:0] dep;
        logic [31:0] off;
        logic [31:0] w;
        logic [31:0] h;
        int          cut;
        bit          flagged;
        decoder_clear();

        queue_file(mbsp_pkg::SIGNATURE, 30, 1, 1, 1, 1'b0, -1, 2, 1'b0, 1'b0);
        queue_file(16'h424D, 30, 8, 8, 1, 1'b1, 2, 1, 1'b0, 1'b0);
        queue_file(mbsp_pkg::SIGNATURE, 30, 32'h8000_0000, 8, 1, 1'b1, -1, 1, 1'b0, 1'b0);
        queue_file(mbsp_pkg::SIGNATURE, 30, 8, 65, 1, 1'b1, -1, 1, 1'b0, 1'b0);
        queue_file(mbsp_pkg::SIGNATURE, 30, 8, 0, 8, 1'b1, -1, 1, 1'b0, 1'b0);
        queue_file(mbsp_pkg::SIGNATURE, 30, 8, 8, 16'h0101, 1'b1, -1, 1, 1'b0, 1'b0);
        queue_file(mbsp_pkg::SIGNATURE, 29, 8, 8, 1, 1'b1, -1, 2, 1'b0, 1'b0);
        queue_file(mbsp_pkg::SIGNATURE, 30, 128, 2, 1, 1'b1, -1, 2, 1'b0, 1'b1);
        queue_file(mbsp_pkg::SIGNATURE, 31, 3, 64, 1, 1'b1, 47, 2, 1'b1, 1'b0);
        queue_file(mbsp_pkg::SIGNATURE, 30, 9, 3, 1, 1'b1, 15, 0, 1'b0, 1'b0);

        while (stream_bytes < ITEMS)
        begin
            sig     = mbsp_pkg::SIGNATURE;
            dep     = 16'd1;
            w       = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 32);
            h       = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
            off     = mbsp_pkg::MIN_OFFSET
                    + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0);
            cut     = -1;
            flagged = 1'b1;
            case ($urandom_range(0, 15))
                0: sig = 16'($urandom);
                1:
                begin
                    case ($urandom_range(0, 2))
                        0:       w = 0;
                        1:       w = $urandom | 32'h8000_0000;
                        default: w = $urandom_range(129, 1000);
                    endcase
                end
                2: h = ($urandom_range(0, 1) == 0) ? $urandom_range(65, 300) : $urandom;
                3: dep = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
                4: off = $urandom_range(0, 29);
                5: cut = $urandom_range(1, 40);
                6: flagged = 1'b0;
                default: ;
            endcase
            queue_file(sig, off, w, h, dep, flagged, cut, $urandom_range(0, 3),
                       $urandom_range(0, 15) == 0, 1'b0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_feed.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("streamed %0d bytes in %0d files; checked %0d pixel writes, %0d done, %0d faults",
                 bytes_taken, files_queued, pixels_seen, done_seen, faults_seen);
        $display("%0d mismatching results, %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("mono_bmp_stream_to_pixels_top: match");
        else
            $display("mono_bmp_stream_to_pixels_top: mismatch");
        $finish;
    end

endmodule
